// ===== hw/rtl/plcm_pkg.sv =====
// ----------------------------------------------------------------------------
// plcm_pkg
// Shared types and constants of the piecewise linear color map unit.
// ----------------------------------------------------------------------------
package plcm_pkg;

	localparam int MaxPoints = 10;
	localparam int IdxW      = $clog2(MaxPoints);
	localparam int CntW      = $clog2(MaxPoints + 1);
	localparam int OutCntW   = 4;

	localparam logic [1:0] StOk   = 2'd0;
	localparam logic [1:0] StFull = 2'd1;
	localparam logic [1:0] StFew  = 2'd2;
	localparam logic [1:0] StFlat = 2'd3;

	localparam logic KindAdd    = 1'b0;
	localparam logic KindLookup = 1'b1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECIDE,
		S_SCAN,
		S_FETCH,
		S_PREP,
		S_MUL,
		S_DIV,
		S_SCALE,
		S_OUT
	} state_t;

	// Controller to datapath.
	typedef struct packed {
		logic load;      // capture input beat
		logic append;    // write point at count
		logic scan_init; // start segment search
		logic scan_step; // compare one point
		logic fetch;     // latch segment endpoints
		logic prep;      // form differences, select channel
		logic mul;       // product for current channel
		logic div_start;
		logic scale;     // clamp, scale, store channel
		logic next_ch;
		logic set_status;
		logic [1:0] status;
		logic out_load;
	} ctrl_t;

	// Datapath to controller.
	typedef struct packed {
		logic is_lookup;
		logic full;
		logic few;
		logic scan_done;
		logic flat;
		logic div_done;
		logic last_ch;
	} stat_t;

endpackage

// ===== hw/rtl/plcm_div.sv =====
// ----------------------------------------------------------------------------
// plcm_div
// Restoring unsigned divider, one quotient bit per cycle, with sign fixup
// for truncation toward zero.
// ----------------------------------------------------------------------------
module plcm_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [33:0] num,
	input  logic signed [16:0] den,
	output logic               done,
	output logic signed [33:0] quo
);

	logic [33:0] n_q;
	logic [16:0] d_q;
	logic [33:0] rem_q;
	logic [5:0]  cnt_q;
	logic        neg_q;
	logic        busy_q;
	logic [34:0] trial;
	logic [33:0] rem_sh;

	assign rem_sh = {rem_q[32:0], n_q[33]};
	assign trial  = {1'b0, rem_sh} - {18'd0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 6'd34;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 6'd1;
			if (cnt_q == 6'd1) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= num[33] ? 34'(-num) : num;
			d_q   <= den[16] ? 17'(-den) : den;
			neg_q <= num[33] ^ den[16];
			rem_q <= '0;
		end else if (busy_q) begin
			if (!trial[34]) begin
				rem_q <= trial[33:0];
				n_q   <= {n_q[32:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				n_q   <= {n_q[32:0], 1'b0};
			end
		end
	end

	assign done = !busy_q && !start;
	assign quo  = neg_q ? 34'(-n_q) : n_q;

endmodule

// ===== hw/rtl/plcm_datapath.sv =====
// ----------------------------------------------------------------------------
// plcm_datapath
// Point table, segment search index, interpolation and output registers.
// ----------------------------------------------------------------------------
module plcm_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  plcm_pkg::ctrl_t      ctrl,
	output plcm_pkg::stat_t      stat,
	input  logic                 kind,
	input  logic [15:0]          position,
	input  logic [15:0]          point_red,
	input  logic [15:0]          point_green,
	input  logic [15:0]          point_blue,
	input  logic [16:0]          opacity,
	output logic [15:0]          red,
	output logic [15:0]          green,
	output logic [15:0]          blue,
	output logic [1:0]           status,
	output logic [3:0]           stored_points
);

	logic [15:0] pos_mem   [plcm_pkg::MaxPoints];
	logic [15:0] red_mem   [plcm_pkg::MaxPoints];
	logic [15:0] green_mem [plcm_pkg::MaxPoints];
	logic [15:0] blue_mem  [plcm_pkg::MaxPoints];

	logic [plcm_pkg::CntW-1:0] count_q;
	logic [plcm_pkg::IdxW-1:0] hi_q;
	logic                      kind_q;
	logic [15:0]               lpos_q, in_r_q, in_g_q, in_b_q;
	logic [16:0]               opac_q;
	logic [15:0]               plo_q, phi_q;
	logic [15:0]               clo_q [3];
	logic [15:0]               chi_q [3];
	logic [1:0]                ch_q;
	logic signed [16:0]        dpos_q, width_q, dc_q;
	logic signed [33:0]        prod_q;
	logic [15:0]               res_q [3];
	logic [1:0]                st_q;
	logic                      div_done;
	logic signed [33:0]        quo;
	logic signed [34:0]        v;
	logic [15:0]               vc;
	logic [32:0]               sc;
	logic [plcm_pkg::CntW-1:0] last_idx;

	assign last_idx = count_q - plcm_pkg::CntW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctrl.append) begin
			count_q <= count_q + plcm_pkg::CntW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			kind_q <= kind;
			lpos_q <= position;
			in_r_q <= point_red;
			in_g_q <= point_green;
			in_b_q <= point_blue;
			opac_q <= opacity;
		end
		if (ctrl.append) begin
			pos_mem[count_q[plcm_pkg::IdxW-1:0]]   <= lpos_q;
			red_mem[count_q[plcm_pkg::IdxW-1:0]]   <= in_r_q;
			green_mem[count_q[plcm_pkg::IdxW-1:0]] <= in_g_q;
			blue_mem[count_q[plcm_pkg::IdxW-1:0]]  <= in_b_q;
		end
		if (ctrl.scan_init) begin
			hi_q <= plcm_pkg::IdxW'(1);
		end else if (ctrl.scan_step && !stat.scan_done) begin
			hi_q <= hi_q + plcm_pkg::IdxW'(1);
		end
		if (ctrl.fetch) begin
			plo_q    <= pos_mem[hi_q - plcm_pkg::IdxW'(1)];
			phi_q    <= pos_mem[hi_q];
			clo_q[0] <= red_mem[hi_q - plcm_pkg::IdxW'(1)];
			chi_q[0] <= red_mem[hi_q];
			clo_q[1] <= green_mem[hi_q - plcm_pkg::IdxW'(1)];
			chi_q[1] <= green_mem[hi_q];
			clo_q[2] <= blue_mem[hi_q - plcm_pkg::IdxW'(1)];
			chi_q[2] <= blue_mem[hi_q];
			ch_q     <= 2'd0;
		end
		if (ctrl.prep) begin
			dpos_q  <= $signed({1'b0, lpos_q}) - $signed({1'b0, plo_q});
			width_q <= $signed({1'b0, phi_q}) - $signed({1'b0, plo_q});
			dc_q    <= $signed({1'b0, chi_q[ch_q]}) - $signed({1'b0, clo_q[ch_q]});
		end
		if (ctrl.mul) begin
			prod_q <= 34'(dpos_q * dc_q);
		end
		if (ctrl.scale) begin
			res_q[ch_q] <= (sc[32:16] > 17'd65535) ? 16'hFFFF : sc[31:16];
		end
		if (ctrl.next_ch) begin
			ch_q <= ch_q + 2'd1;
		end
		if (ctrl.load) begin
			res_q[0] <= '0;
			res_q[1] <= '0;
			res_q[2] <= '0;
			st_q     <= plcm_pkg::StOk;
		end else if (ctrl.set_status) begin
			st_q <= ctrl.status;
		end
		if (ctrl.out_load) begin
			red           <= res_q[0];
			green         <= res_q[1];
			blue          <= res_q[2];
			status        <= st_q;
			stored_points <= plcm_pkg::OutCntW'(count_q);
		end
	end

	plcm_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (ctrl.div_start),
		.num   (prod_q),
		.den   (width_q),
		.done  (div_done),
		.quo   (quo)
	);

	// Clamp the interpolated channel, then scale by opacity.
	always_comb begin
		v = $signed({19'd0, clo_q[ch_q]}) + 35'(quo);
		if (v < 0) begin
			vc = '0;
		end else if (v > 35'sd65535) begin
			vc = 16'hFFFF;
		end else begin
			vc = v[15:0];
		end
		sc = 33'(vc) * 33'(opac_q);
	end

	assign stat.is_lookup = kind_q == plcm_pkg::KindLookup;
	assign stat.full      = count_q >= plcm_pkg::CntW'(plcm_pkg::MaxPoints);
	assign stat.few       = count_q < plcm_pkg::CntW'(2);
	assign stat.scan_done = (plcm_pkg::CntW'(hi_q) >= last_idx) || (lpos_q < pos_mem[hi_q]);
	assign stat.flat      = width_q == '0;
	assign stat.div_done  = div_done;
	assign stat.last_ch   = ch_q == 2'd2;

endmodule

// ===== hw/rtl/plcm_ctrl.sv =====
// ----------------------------------------------------------------------------
// plcm_ctrl
// Sequencer for append and lookup items.
// ----------------------------------------------------------------------------
module plcm_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	input  plcm_pkg::stat_t stat,
	output plcm_pkg::ctrl_t ctrl
);

	plcm_pkg::state_t state_q, state_d;
	logic             ov_q, ov_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= plcm_pkg::S_IDLE;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			ov_q    <= ov_d;
		end
	end

	assign in_ready  = state_q == plcm_pkg::S_IDLE;
	assign out_valid = ov_q;

	always_comb begin
		state_d = state_q;
		ov_d    = ov_q && !out_ready;
		ctrl    = '0;
		unique case (state_q)
			plcm_pkg::S_IDLE: begin
				if (in_valid) begin
					ctrl.load = 1'b1;
					state_d   = plcm_pkg::S_DECIDE;
				end
			end
			plcm_pkg::S_DECIDE: begin
				state_d = plcm_pkg::S_OUT;
				if (!stat.is_lookup) begin
					if (stat.full) begin
						ctrl.set_status = 1'b1;
						ctrl.status     = plcm_pkg::StFull;
					end else begin
						ctrl.append = 1'b1;
					end
				end else if (stat.few) begin
					ctrl.set_status = 1'b1;
					ctrl.status     = plcm_pkg::StFew;
				end else begin
					ctrl.scan_init = 1'b1;
					state_d        = plcm_pkg::S_SCAN;
				end
			end
			plcm_pkg::S_SCAN: begin
				ctrl.scan_step = 1'b1;
				if (stat.scan_done) begin
					state_d = plcm_pkg::S_FETCH;
				end
			end
			plcm_pkg::S_FETCH: begin
				ctrl.fetch = 1'b1;
				state_d    = plcm_pkg::S_PREP;
			end
			plcm_pkg::S_PREP: begin
				ctrl.prep = 1'b1;
				state_d   = plcm_pkg::S_MUL;
			end
			plcm_pkg::S_MUL: begin
				if (stat.flat) begin
					ctrl.set_status = 1'b1;
					ctrl.status     = plcm_pkg::StFlat;
					state_d         = plcm_pkg::S_OUT;
				end else begin
					ctrl.mul = 1'b1;
					state_d  = plcm_pkg::S_DIV;
				end
			end
			plcm_pkg::S_DIV: begin
				ctrl.div_start = 1'b1;
				state_d        = plcm_pkg::S_SCALE;
			end
			plcm_pkg::S_SCALE: begin
				if (stat.div_done) begin
					ctrl.scale = 1'b1;
					if (stat.last_ch) begin
						state_d = plcm_pkg::S_OUT;
					end else begin
						ctrl.next_ch = 1'b1;
						state_d      = plcm_pkg::S_PREP;
					end
				end
			end
			plcm_pkg::S_OUT: begin
				if (!ov_q || out_ready) begin
					ctrl.out_load = 1'b1;
					ov_d          = 1'b1;
					state_d       = plcm_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = plcm_pkg::S_IDLE;
			end
		endcase
	end

endmodule

// ===== hw/rtl/piecewise_linear_color_map_unit.sv =====
// ----------------------------------------------------------------------------
// piecewise_linear_color_map_unit
// Piecewise linear color map: appends control points and looks up colors.
// ----------------------------------------------------------------------------
// Sequence: an append is decided and its result loaded; a lookup searches
// for its segment one point at a time, then for each channel preps,
// multiplies and divides before the result loads.
// Throughput: one item at a time; the next beat is taken only once the
// result has loaded and the controller is back in idle.
// Reset: arst_n clears the point count and the controller; stored points
// are not cleared and are never read before they are written.
// ----------------------------------------------------------------------------
module piecewise_linear_color_map_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        kind,
	input  logic [15:0] position,
	input  logic [15:0] point_red,
	input  logic [15:0] point_green,
	input  logic [15:0] point_blue,
	input  logic [16:0] opacity,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] red,
	output logic [15:0] green,
	output logic [15:0] blue,
	output logic [1:0]  status,
	output logic [3:0]  stored_points
);

	// The controller sequences each item; the datapath holds the points,
	// the search index, the divider and the result register.
	plcm_pkg::ctrl_t ctrl;
	plcm_pkg::stat_t stat;

	plcm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.stat     (stat),
		.ctrl     (ctrl)
	);

	plcm_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ctrl),
		.stat         (stat),
		.kind         (kind),
		.position     (position),
		.point_red    (point_red),
		.point_green  (point_green),
		.point_blue   (point_blue),
		.opacity      (opacity),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.status       (status),
		.stored_points(stored_points)
	);

endmodule

// ===== hw/rtl/plcm_checker.sv =====
// ----------------------------------------------------------------------------
// plcm_checker
// Port-level checks of the color map unit.
// ----------------------------------------------------------------------------
module plcm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] red,
	input logic [1:0]  status,
	input logic [3:0]  stored_points
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(red))
		else $error("result beat changed while stalled");

	a_one_at_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second beat taken while busy");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != 2'd0 |-> red == 16'd0)
		else $error("nonzero color with error status");

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> stored_points <= 4'(plcm_pkg::MaxPoints))
		else $error("point count beyond table size");

endmodule

bind piecewise_linear_color_map_unit plcm_checker u_plcm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.red          (red),
	.status       (status),
	.stored_points(stored_points)
);

// ===== tb/sv/piecewise_linear_color_map_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piecewise_linear_color_map_unit_tb
// Self-checking bench for the piecewise linear color map unit. A driver
// offers append and lookup beats from a queue, a monitor takes result beats
// and compares each against a software prediction of the point table and
// the interpolation, field by field, in order.
// ----------------------------------------------------------------------------
module piecewise_linear_color_map_unit_tb;

	typedef struct packed {
		logic        kind;
		logic [15:0] position;
		logic [15:0] point_red;
		logic [15:0] point_green;
		logic [15:0] point_blue;
		logic [16:0] opacity;
	} map_req_t;

	typedef struct packed {
		logic [15:0] red;
		logic [15:0] green;
		logic [15:0] blue;
		logic [1:0]  status;
		logic [3:0]  stored_points;
	} map_rsp_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        kind;
	logic [15:0] position;
	logic [15:0] point_red;
	logic [15:0] point_green;
	logic [15:0] point_blue;
	logic [16:0] opacity;
	logic        out_valid;
	logic        out_ready;
	logic [15:0] red;
	logic [15:0] green;
	logic [15:0] blue;
	logic [1:0]  status;
	logic [3:0]  stored_points;

	// Predicted point table, a private copy of what the block should hold.
	logic [15:0] tbl_pos [plcm_pkg::MaxPoints];
	logic [15:0] tbl_red [plcm_pkg::MaxPoints];
	logic [15:0] tbl_grn [plcm_pkg::MaxPoints];
	logic [15:0] tbl_blu [plcm_pkg::MaxPoints];
	int          tbl_count;

	map_req_t pending_beats[$];
	map_rsp_t expected_colors[$];

	int  send_idle_pct;
	int  recv_idle_pct;
	int  hold_off_cycles;
	bit  hold_off_taken;
	int  run_phase;
	int  error_count;
	int  lookups_checked;
	int  beats_checked;

	piecewise_linear_color_map_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.kind(kind), .position(position), .point_red(point_red),
		.point_green(point_green), .point_blue(point_blue), .opacity(opacity),
		.out_valid(out_valid), .out_ready(out_ready),
		.red(red), .green(green), .blue(blue),
		.status(status), .stored_points(stored_points)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// One channel of a lookup: the line through the segment ends, clamped to
	// the color range, then scaled by opacity with saturation.
	function automatic logic [15:0] shade_channel(longint c_lo, longint c_hi,
			longint dpos, longint width, longint opac);
		longint v;
		longint s;
		v = c_lo + (dpos * (c_hi - c_lo)) / width;
		if (v < 0)
			v = 0;
		if (v > 65535)
			v = 65535;
		s = (v * opac) >>> 16;
		if (s > 65535)
			s = 65535;
		return s[15:0];
	endfunction

	// Apply one accepted beat to the predicted table and queue its result.
	function automatic void predict_color(map_req_t b);
		map_rsp_t r;
		int       hi;
		int       lo;
		longint   width;
		longint   dpos;
		r = '0;
		r.status = plcm_pkg::StOk;
		if (b.kind == plcm_pkg::KindAdd) begin
			if (tbl_count >= plcm_pkg::MaxPoints) begin
				r.status = plcm_pkg::StFull;
			end else begin
				tbl_pos[tbl_count] = b.position;
				tbl_red[tbl_count] = b.point_red;
				tbl_grn[tbl_count] = b.point_green;
				tbl_blu[tbl_count] = b.point_blue;
				tbl_count++;
			end
		end else if (tbl_count < 2) begin
			r.status = plcm_pkg::StFew;
		end else begin
			// The first interior point above the position ends the segment;
			// otherwise the last point does, which extrapolates at the ends.
			hi = 1;
			while (hi < tbl_count - 1 && !(b.position < tbl_pos[hi]))
				hi++;
			lo = hi - 1;
			width = longint'(tbl_pos[hi]) - longint'(tbl_pos[lo]);
			if (width == 0) begin
				r.status = plcm_pkg::StFlat;
			end else begin
				dpos = longint'(b.position) - longint'(tbl_pos[lo]);
				r.red   = shade_channel(tbl_red[lo], tbl_red[hi], dpos, width, b.opacity);
				r.green = shade_channel(tbl_grn[lo], tbl_grn[hi], dpos, width, b.opacity);
				r.blue  = shade_channel(tbl_blu[lo], tbl_blu[hi], dpos, width, b.opacity);
			end
		end
		r.stored_points = tbl_count[3:0];
		expected_colors.push_back(r);
	endfunction

	// Driver: offers the next queued beat, holding it steady until accepted.
	// Beats are predicted at the edge that accepts them.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid    <= 1'b0;
			kind        <= plcm_pkg::KindAdd;
			position    <= '0;
			point_red   <= '0;
			point_green <= '0;
			point_blue  <= '0;
			opacity     <= '0;
		end else begin
			if (in_valid && in_ready) begin
				predict_color({kind, position, point_red, point_green, point_blue, opacity});
			end
			if (!in_valid || in_ready) begin
				if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					map_req_t b;
					b = pending_beats.pop_front();
					in_valid    <= 1'b1;
					kind        <= b.kind;
					position    <= b.position;
					point_red   <= b.point_red;
					point_green <= b.point_green;
					point_blue  <= b.point_blue;
					opacity     <= b.opacity;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver readiness lives in its own process. At the start of phase two
	// it keeps ready low for a counted stretch so the block backs up into its
	// input.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready       <= 1'b0;
			hold_off_cycles <= 0;
			hold_off_taken  <= 1'b0;
		end else if (run_phase == 2 && !hold_off_taken) begin
			hold_off_taken  <= 1'b1;
			hold_off_cycles <= 600;
			out_ready       <= 1'b0;
		end else if (hold_off_cycles > 0) begin
			hold_off_cycles <= hold_off_cycles - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Monitor: every result beat is checked against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_colors.size() == 0) begin
				$display("%0t: unexpected result beat r=%h g=%h b=%h st=%0d n=%0d",
					$time, red, green, blue, status, stored_points);
				error_count++;
			end else begin
				map_rsp_t e;
				e = expected_colors.pop_front();
				if (red !== e.red) begin
					$display("%0t: red expected %h actual %h", $time, e.red, red);
					error_count++;
				end
				if (green !== e.green) begin
					$display("%0t: green expected %h actual %h", $time, e.green, green);
					error_count++;
				end
				if (blue !== e.blue) begin
					$display("%0t: blue expected %h actual %h", $time, e.blue, blue);
					error_count++;
				end
				if (status !== e.status) begin
					$display("%0t: status expected %0d actual %0d", $time, e.status, status);
					error_count++;
				end
				if (stored_points !== e.stored_points) begin
					$display("%0t: stored_points expected %0d actual %0d",
						$time, e.stored_points, stored_points);
					error_count++;
				end
				beats_checked++;
				if (e.status == plcm_pkg::StOk && e.red + e.green + e.blue != 0)
					lookups_checked++;
			end
		end
	end

	function automatic map_req_t add_beat(logic [15:0] p, logic [15:0] r,
			logic [15:0] g, logic [15:0] b);
		map_req_t x;
		x = {plcm_pkg::KindAdd, p, r, g, b, 17'($urandom_range(131071))};
		return x;
	endfunction

	function automatic map_req_t lookup_beat(logic [15:0] p, logic [16:0] o);
		map_req_t x;
		x = {plcm_pkg::KindLookup, p, 16'($urandom), 16'($urandom), 16'($urandom), o};
		return x;
	endfunction

	function automatic logic [16:0] rand_opacity();
		case ($urandom_range(5))
			0: return 17'd65536;
			1: return 17'h1FFFF;
			2: return 17'd0;
			default: return 17'($urandom_range(131071));
		endcase
	endfunction

	// The table only ever grows, so a fresh map needs a reset. Reset is used
	// once, so the run builds a single table: a few adds, many lookups, a fill.
	// Each random round still varies the lookup positions across the whole range.
	task automatic queue_beats(int n_items);
		int i;
		int k;
		logic [15:0] p;
		// Directed: lookups on an empty and one-point table, a zero-width
		// first segment, extremes of every field, then a third point below the others.
		pending_beats.push_back(lookup_beat(16'd0, 17'd65536));
		pending_beats.push_back(add_beat(16'd100, 16'hFFFF, 16'd0, 16'h8000));
		pending_beats.push_back(lookup_beat(16'hFFFF, 17'h1FFFF));
		pending_beats.push_back(add_beat(16'd100, 16'd0, 16'hFFFF, 16'd1));
		pending_beats.push_back(lookup_beat(16'd50, 17'd65536));
		pending_beats.push_back(lookup_beat(16'd100, 17'd65536));
		pending_beats.push_back(add_beat(16'd0, 16'h1234, 16'hFFFF, 16'd0));
		pending_beats.push_back(lookup_beat(16'd0, 17'd65536));
		pending_beats.push_back(lookup_beat(16'd0, 17'h1FFFF));
		pending_beats.push_back(lookup_beat(16'hFFFF, 17'd65536));
		pending_beats.push_back(lookup_beat(16'd7, 17'd0));
		// Random part: mostly lookups, with adds mixed in.
		for (i = 0; i < n_items; i++) begin
			k = $urandom_range(99);
			if (k < 6) begin
				p = (k < 2) ? 16'hFFFF : 16'($urandom);
				pending_beats.push_back(add_beat(p, 16'($urandom), 16'($urandom),
					16'($urandom)));
			end else begin
				case ($urandom_range(3))
					0: p = 16'($urandom_range(0, 3));
					1: p = 16'($urandom_range(65532, 65535));
					default: p = 16'($urandom);
				endcase
				pending_beats.push_back(lookup_beat(p, rand_opacity()));
			end
		end
		// Finish filling the table and overflow it.
		for (i = 0; i < plcm_pkg::MaxPoints + 2; i++)
			pending_beats.push_back(add_beat(16'($urandom), 16'($urandom),
				16'($urandom), 16'($urandom)));
		for (i = 0; i < 40; i++)
			pending_beats.push_back(lookup_beat(16'($urandom), rand_opacity()));
	endtask

	task automatic drain_queue();
		while (pending_beats.size() != 0 || in_valid)
			@(posedge clk);
	endtask

	initial begin
		arst_n          = 1'b0;
		send_idle_pct   = 21;
		recv_idle_pct   = 47;
		run_phase       = 0;
		error_count     = 0;
		lookups_checked = 0;
		beats_checked   = 0;
		tbl_count       = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Phase one: sender idles 21 percent, receiver 47.
		run_phase = 1;
		queue_beats(390);
		drain_queue();
		// Phase two: swap the idle rates; the receiver starts with a long
		// hold-off while beats keep coming, so the block backs up.
		send_idle_pct = 47;
		recv_idle_pct = 21;
		run_phase = 2;
		queue_beats(390);
		drain_queue();
		// Phase three: no idling on either side.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_phase = 3;
		queue_beats(390);
		drain_queue();

		while (expected_colors.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		$display("Checked %0d result beats, %0d of them nonzero lookups;", beats_checked,
			lookups_checked);
		$display("covered empty, flat, full and extrapolated cases under three idle mixes.");
		if (error_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	// Timeout for the slowest run: the lookups of all three phases, stalls and gaps included.
	initial begin
		#2000000;
		$display("FAIL");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/plcm_pkg.sv
hw/rtl/plcm_div.sv
hw/rtl/plcm_datapath.sv
hw/rtl/plcm_ctrl.sv
hw/rtl/piecewise_linear_color_map_unit.sv
hw/rtl/plcm_checker.sv
tb/sv/piecewise_linear_color_map_unit_tb.sv
